@@ rtl/core/vna_pkg.sv @@
// vna_pkg: shared types, widths and codes of the vertex normal accumulator
// used by every module under rtl/core except vna_ram; depends on nothing
package vna_pkg;

   localparam int VERTICES_DEF = 1024;
   localparam int QUEUE_DEPTH  = 4;

   localparam int IDX_W      = 10;
   localparam int COORD_W    = 16;
   localparam int ACC_W      = 48;
   localparam int EDGE_W     = 17;
   localparam int PROD_W     = 34;
   localparam int CROSS_W    = 35;
   localparam int COMP_W     = 16;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 64;

   // item kind carried in req_tuser
   typedef enum logic [1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_TRI  = 2'd1,
      FUNC_READ = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   // classified work for the back end
   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_TRI      = 2'd1,
      OP_READ     = 2'd2,
      OP_READ_BAD = 2'd3
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [IDX_W-1:0]         vertex;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] pz;
      logic [IDX_W-1:0]         ca;
      logic [IDX_W-1:0]         cb;
      logic [IDX_W-1:0]         cc;
   } cmd_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } pos_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
      logic signed [ACC_W-1:0] z;
   } acc_type;

   typedef struct packed {
      logic [IDX_W-1:0]          vertex;
      logic signed [COMP_W-1:0]  x;
      logic signed [COMP_W-1:0]  y;
      logic signed [COMP_W-1:0]  z;
      logic                      degenerate;
   } result_type;

   // back end status seen by the front end
   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

@@ rtl/core/vna_ram.sv @@
// vna_ram: generic single write, single read port ram with registered read
// depends on nothing
module vna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/vna_queue.sv @@
// vna_queue: short command queue between front and back end
// depends on vna_pkg (cmd_type); DEPTH must be a power of two
module vna_queue import vna_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   localparam int PTR_W = $clog2(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic [PTR_W:0]   count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (PTR_W+1)'(DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/vna_front.sv @@
// vna_front: accepts request items, range-checks and classifies them
// depends on vna_pkg (cmd_type, func_type, back_status_type)
module vna_front import vna_pkg::*; #(
   parameter int VERTICES = VERTICES_DEF
) (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  back_status_type       status,
   input  logic                  q_full,
   output logic                  push,
   output cmd_type               push_cmd
);

   func_type         func;
   logic [IDX_W-1:0] vi;
   logic [IDX_W-1:0] ia;
   logic [IDX_W-1:0] ib;
   logic [IDX_W-1:0] ic;
   logic             keep;

   assign func = func_type'(req_tuser);
   assign vi   = req_tdata[9:0];
   assign ia   = req_tdata[67:58];
   assign ib   = req_tdata[77:68];
   assign ic   = req_tdata[87:78];

   // classify: drop unused codes and out-of-range loads and triangles
   always_comb begin
      push_cmd.vertex = vi;
      push_cmd.px     = req_tdata[25:10];
      push_cmd.py     = req_tdata[41:26];
      push_cmd.pz     = req_tdata[57:42];
      push_cmd.ca     = ia;
      push_cmd.cb     = ib;
      push_cmd.cc     = ic;
      push_cmd.op     = OP_LOAD;
      keep            = 1'b0;
      unique case (func)
         FUNC_LOAD: begin
            push_cmd.op = OP_LOAD;
            keep        = (32'(vi) < VERTICES);
         end
         FUNC_TRI: begin
            push_cmd.op = OP_TRI;
            keep        = (32'(ia) < VERTICES) && (32'(ib) < VERTICES)
                          && (32'(ic) < VERTICES);
         end
         FUNC_READ: begin
            push_cmd.op = (32'(vi) < VERTICES) ? OP_READ : OP_READ_BAD;
            keep        = 1'b1;
         end
         FUNC_NONE: begin
            push_cmd.op = OP_LOAD;
            keep        = 1'b0;
         end
      endcase
   end

   // no item is taken while the accumulators are being cleared
   assign req_tready = !q_full && !status.clearing;
   assign push       = req_tvalid && req_tready && keep;

endmodule

@@ rtl/core/vna_norm.sv @@
// vna_norm: multi-cycle normalizer, shift search, square root, three dividers
// depends on vna_pkg (acc_type, widths)
module vna_norm import vna_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  acc_type                  sum,
   output logic                     done,
   output logic signed [COMP_W-1:0] out_x,
   output logic signed [COMP_W-1:0] out_y,
   output logic signed [COMP_W-1:0] out_z,
   output logic                     degenerate
);

   typedef enum logic [3:0] {
      N_IDLE, N_MAX, N_SHIFT, N_SQ, N_SUM, N_SQRT, N_DIVINIT, N_DIV, N_DONE
   } nstate_type;

   nstate_type         state_ff;
   logic               neg_ff  [3];
   logic [ACC_W-1:0]   mag_ff  [3];
   logic [ACC_W-1:0]   m_ff;
   logic [59:0]        sq_ff   [3];
   logic [63:0]        root_v_ff;
   logic [63:0]        root_r_ff;
   logic [63:0]        root_bit_ff;
   logic [45:0]        rem_ff  [3];
   logic [44:0]        div_ff;
   logic [14:0]        quo_ff  [3];
   logic [3:0]         step_ff;
   logic               done_ff;
   logic signed [COMP_W-1:0] out_ff [3];
   logic               deg_ff;

   logic signed [ACC_W-1:0] comp [3];
   logic [ACC_W-1:0]   m_max;
   logic [63:0]        trial;
   logic [30:0]        len;

   assign comp[0] = sum.x;
   assign comp[1] = sum.y;
   assign comp[2] = sum.z;
   assign m_max = (mag_ff[0] >= mag_ff[1])
                  ? ((mag_ff[0] >= mag_ff[2]) ? mag_ff[0] : mag_ff[2])
                  : ((mag_ff[1] >= mag_ff[2]) ? mag_ff[1] : mag_ff[2]);
   assign trial = root_r_ff + root_bit_ff;
   assign len   = root_r_ff[30:0];

   // sequencer with datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            N_IDLE: begin
               if (start) begin
                  for (int i = 0; i < 3; i++) begin
                     neg_ff[i] <= comp[i][ACC_W-1];
                     mag_ff[i] <= comp[i][ACC_W-1] ? ACC_W'(-comp[i]) : ACC_W'(comp[i]);
                  end
                  state_ff <= N_MAX;
               end
            end
            N_MAX: begin
               m_ff <= m_max;
               if (m_max == '0) begin
                  for (int i = 0; i < 3; i++) begin
                     out_ff[i] <= '0;
                  end
                  deg_ff   <= 1'b1;
                  done_ff  <= 1'b1;
                  state_ff <= N_IDLE;
               end else begin
                  state_ff <= N_SHIFT;
               end
            end
            // one bit a cycle until the largest magnitude lies in [2^29, 2^30)
            N_SHIFT: begin
               if (m_ff[ACC_W-1:30] != '0) begin
                  m_ff <= m_ff >> 1;
                  for (int i = 0; i < 3; i++) begin
                     mag_ff[i] <= mag_ff[i] >> 1;
                  end
               end else if (!m_ff[29]) begin
                  m_ff <= m_ff << 1;
                  for (int i = 0; i < 3; i++) begin
                     mag_ff[i] <= mag_ff[i] << 1;
                  end
               end else begin
                  state_ff <= N_SQ;
               end
            end
            N_SQ: begin
               for (int i = 0; i < 3; i++) begin
                  sq_ff[i] <= mag_ff[i][29:0] * mag_ff[i][29:0];
               end
               state_ff <= N_SUM;
            end
            N_SUM: begin
               root_v_ff   <= 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
               root_r_ff   <= '0;
               root_bit_ff <= 64'(1) << 62;
               state_ff    <= N_SQRT;
            end
            // one result bit a cycle
            N_SQRT: begin
               if (root_bit_ff == '0) begin
                  state_ff <= N_DIVINIT;
               end else begin
                  if (root_v_ff >= trial) begin
                     root_v_ff <= root_v_ff - trial;
                     root_r_ff <= (root_r_ff >> 1) + root_bit_ff;
                  end else begin
                     root_r_ff <= root_r_ff >> 1;
                  end
                  root_bit_ff <= root_bit_ff >> 2;
               end
            end
            N_DIVINIT: begin
               for (int i = 0; i < 3; i++) begin
                  rem_ff[i] <= 46'({mag_ff[i][29:0], 14'b0}) + 46'(len >> 1);
                  quo_ff[i] <= '0;
               end
               div_ff   <= {len, 14'b0};
               step_ff  <= '0;
               state_ff <= N_DIV;
            end
            // restoring division, one quotient bit a cycle in each lane
            N_DIV: begin
               for (int i = 0; i < 3; i++) begin
                  if (rem_ff[i] >= {1'b0, div_ff}) begin
                     rem_ff[i] <= rem_ff[i] - {1'b0, div_ff};
                     quo_ff[i] <= {quo_ff[i][13:0], 1'b1};
                  end else begin
                     quo_ff[i] <= {quo_ff[i][13:0], 1'b0};
                  end
               end
               div_ff  <= div_ff >> 1;
               step_ff <= step_ff + 1'b1;
               if (step_ff == 4'd14) begin
                  state_ff <= N_DONE;
               end
            end
            N_DONE: begin
               for (int i = 0; i < 3; i++) begin
                  out_ff[i] <= neg_ff[i] ? -COMP_W'(quo_ff[i]) : COMP_W'(quo_ff[i]);
               end
               deg_ff   <= 1'b0;
               done_ff  <= 1'b1;
               state_ff <= N_IDLE;
            end
         endcase
      end
   end

   assign done       = done_ff;
   assign out_x      = out_ff[0];
   assign out_y      = out_ff[1];
   assign out_z      = out_ff[2];
   assign degenerate = deg_ff;

endmodule

@@ rtl/core/vna_back.sv @@
// vna_back: executes queued commands against position and accumulator rams
// depends on vna_pkg, vna_ram and vna_norm
module vna_back import vna_pkg::*; #(
   parameter int VERTICES = VERTICES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  cmd_type         q_head,
   output logic            q_pop,
   output back_status_type status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output result_type      result
);

   localparam int ADDR_W = $clog2(VERTICES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VERTICES - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_TRI_RD, S_TRI_MUL, S_TRI_CRS, S_ACC_RD, S_ACC_WR,
      S_NRM_RD, S_NRM_WAIT
   } state_type;

   state_type                  state_ff;
   logic [ADDR_W-1:0]          clr_addr_ff;
   logic [1:0]                 cnt_ff;
   logic [1:0]                 corner_ff;
   logic [ADDR_W-1:0]          ca_ff;
   logic [ADDR_W-1:0]          cb_ff;
   logic [ADDR_W-1:0]          cc_ff;
   pos_type                    pa_ff;
   pos_type                    pb_ff;
   pos_type                    pc_ff;
   logic signed [PROD_W-1:0]   prod_ff [6];
   logic signed [CROSS_W-1:0]  nx_ff;
   logic signed [CROSS_W-1:0]  ny_ff;
   logic signed [CROSS_W-1:0]  nz_ff;
   logic [IDX_W-1:0]           vertex_ff;
   logic                       out_valid_ff;
   result_type                 out_ff;

   logic                       is_read;
   logic                       pop_ok;
   logic                       pos_wr_en;
   logic [ADDR_W-1:0]          pos_rd_addr;
   pos_type                    pos_rd;
   logic                       acc_wr_en;
   logic [ADDR_W-1:0]          acc_wr_addr;
   acc_type                    acc_wr_data;
   logic [ADDR_W-1:0]          acc_rd_addr;
   acc_type                    acc_rd;
   acc_type                    acc_new;
   logic [ADDR_W-1:0]          corner_addr;
   logic signed [EDGE_W-1:0]   e1x, e1y, e1z, e2x, e2y, e2z;
   logic                       nrm_done;
   logic signed [COMP_W-1:0]   nrm_x, nrm_y, nrm_z;
   logic                       nrm_deg;

   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0]   acc,
      input logic signed [CROSS_W-1:0] d
   );
      logic signed [ACC_W:0] s;
      s = (ACC_W+1)'(acc) + (ACC_W+1)'(d);
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return s[ACC_W-1:0];
   endfunction

   // dispatch: a read waits for a free output register
   assign is_read = (q_head.op == OP_READ) || (q_head.op == OP_READ_BAD);
   assign pop_ok  = (state_ff == S_IDLE) && !q_empty && !(is_read && out_valid_ff);
   assign q_pop   = pop_ok;

   assign status.clearing = (state_ff == S_CLEAR);

   assign corner_addr = (corner_ff == 2'd0) ? ca_ff : ((corner_ff == 2'd1) ? cb_ff : cc_ff);

   // ram port steering
   assign pos_wr_en   = pop_ok && (q_head.op == OP_LOAD);
   assign pos_rd_addr = (state_ff == S_TRI_RD) ? ((cnt_ff == 2'd1) ? cb_ff : cc_ff)
                                               : ADDR_W'(q_head.ca);
   assign acc_rd_addr = (state_ff == S_ACC_RD) ? corner_addr : ADDR_W'(q_head.vertex);

   assign acc_new.x = sat_add(acc_rd.x, nx_ff);
   assign acc_new.y = sat_add(acc_rd.y, ny_ff);
   assign acc_new.z = sat_add(acc_rd.z, nz_ff);

   always_comb begin
      acc_wr_en   = 1'b0;
      acc_wr_addr = ADDR_W'(q_head.vertex);
      acc_wr_data = '0;
      priority if (state_ff == S_CLEAR) begin
         acc_wr_en   = 1'b1;
         acc_wr_addr = clr_addr_ff;
      end else if (state_ff == S_ACC_WR) begin
         acc_wr_en   = 1'b1;
         acc_wr_addr = corner_addr;
         acc_wr_data = acc_new;
      end else if (pos_wr_en) begin
         acc_wr_en   = 1'b1;
      end
   end

   vna_ram #(.WIDTH(3*COORD_W), .DEPTH(VERTICES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_wr_en),
      .wr_addr (ADDR_W'(q_head.vertex)),
      .wr_data ({q_head.px, q_head.py, q_head.pz}),
      .rd_en   (1'b1),
      .rd_addr (pos_rd_addr),
      .rd_data (pos_rd)
   );

   vna_ram #(.WIDTH(3*ACC_W), .DEPTH(VERTICES)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_en   (1'b1),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd)
   );

   vna_norm u_norm (
      .clock      (clock),
      .reset      (reset),
      .start      (state_ff == S_NRM_RD),
      .sum        (acc_rd),
      .done       (nrm_done),
      .out_x      (nrm_x),
      .out_y      (nrm_y),
      .out_z      (nrm_z),
      .degenerate (nrm_deg)
   );

   // edge vectors around pivot b
   assign e1x = EDGE_W'(pa_ff.x) - EDGE_W'(pb_ff.x);
   assign e1y = EDGE_W'(pa_ff.y) - EDGE_W'(pb_ff.y);
   assign e1z = EDGE_W'(pa_ff.z) - EDGE_W'(pb_ff.z);
   assign e2x = EDGE_W'(pc_ff.x) - EDGE_W'(pb_ff.x);
   assign e2y = EDGE_W'(pc_ff.y) - EDGE_W'(pb_ff.y);
   assign e2z = EDGE_W'(pc_ff.z) - EDGE_W'(pb_ff.z);

   // sequencer, datapath and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == LAST_ADDR) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (pop_ok) begin
                  unique case (q_head.op)
                     OP_LOAD: begin
                        state_ff <= S_IDLE;
                     end
                     OP_TRI: begin
                        ca_ff    <= ADDR_W'(q_head.ca);
                        cb_ff    <= ADDR_W'(q_head.cb);
                        cc_ff    <= ADDR_W'(q_head.cc);
                        cnt_ff   <= 2'd1;
                        state_ff <= S_TRI_RD;
                     end
                     OP_READ: begin
                        vertex_ff <= q_head.vertex;
                        state_ff  <= S_NRM_RD;
                     end
                     OP_READ_BAD: begin
                        out_ff.vertex     <= q_head.vertex;
                        out_ff.x          <= '0;
                        out_ff.y          <= '0;
                        out_ff.z          <= '0;
                        out_ff.degenerate <= 1'b1;
                        out_valid_ff      <= 1'b1;
                     end
                  endcase
               end
            end
            // positions of a, b, c arrive one a cycle
            S_TRI_RD: begin
               cnt_ff <= cnt_ff + 1'b1;
               unique case (cnt_ff)
                  2'd1: pa_ff <= pos_rd;
                  2'd2: pb_ff <= pos_rd;
                  2'd3: begin
                     pc_ff    <= pos_rd;
                     state_ff <= S_TRI_MUL;
                  end
                  2'd0: state_ff <= S_TRI_MUL;
               endcase
            end
            S_TRI_MUL: begin
               prod_ff[0] <= e2y * e1z;
               prod_ff[1] <= e2z * e1y;
               prod_ff[2] <= e2z * e1x;
               prod_ff[3] <= e2x * e1z;
               prod_ff[4] <= e2x * e1y;
               prod_ff[5] <= e2y * e1x;
               state_ff   <= S_TRI_CRS;
            end
            S_TRI_CRS: begin
               nx_ff     <= CROSS_W'(prod_ff[0]) - CROSS_W'(prod_ff[1]);
               ny_ff     <= CROSS_W'(prod_ff[2]) - CROSS_W'(prod_ff[3]);
               nz_ff     <= CROSS_W'(prod_ff[4]) - CROSS_W'(prod_ff[5]);
               corner_ff <= 2'd0;
               state_ff  <= S_ACC_RD;
            end
            // read-modify-write of each corner, write lands before next read
            S_ACC_RD: begin
               state_ff <= S_ACC_WR;
            end
            S_ACC_WR: begin
               if (corner_ff == 2'd2) begin
                  state_ff <= S_IDLE;
               end else begin
                  corner_ff <= corner_ff + 1'b1;
                  state_ff  <= S_ACC_RD;
               end
            end
            S_NRM_RD: begin
               state_ff <= S_NRM_WAIT;
            end
            S_NRM_WAIT: begin
               if (nrm_done) begin
                  out_ff.vertex     <= vertex_ff;
                  out_ff.x          <= nrm_x;
                  out_ff.y          <= nrm_y;
                  out_ff.z          <= nrm_z;
                  out_ff.degenerate <= nrm_deg;
                  out_valid_ff      <= 1'b1;
                  state_ff          <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign result    = out_ff;

endmodule

@@ rtl/core/vertex_normal_accumulator.sv @@
// vertex_normal_accumulator: top level, front end, command queue, back end
// depends on vna_pkg, vna_front, vna_queue, vna_back
//
//   channel | direction | tdata                                   | tuser
//   req     | in        | vertex_index pos_x pos_y pos_z a b c    | func
//   rsp     | out       | normal_vertex normal_x normal_y normal_z| degenerate
//
// a load is written while the back end stays idle; a triangle runs three
// position reads, multiply, subtract and three accumulator read-modify-writes
// on the shared ram port; a read runs the shift search, the 32-step square
// root and the 15-step dividers of the normalizer; a zero-length read ends
// at the magnitude check and an out-of-range read is answered at dispatch
// after reset the accumulator ram is cleared entry by entry and no item is taken
// the queue accepts items until full while the back end works or rsp stalls
module vertex_normal_accumulator import vna_pkg::*; #(
   parameter int VERTICES = VERTICES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // normal_vertex, normal_x, normal_y, normal_z, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // degenerate
   output logic                  rsp_tuser
);

   back_status_type status;
   logic            q_full;
   logic            q_empty;
   logic            push;
   cmd_type         push_cmd;
   cmd_type         q_head;
   logic            q_pop;
   result_type      result;

   vna_front #(.VERTICES(VERTICES)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   vna_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   vna_back #(.VERTICES(VERTICES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .result    (result)
   );

   assign rsp_tdata = {6'b0, result.z, result.y, result.x, result.vertex};
   assign rsp_tuser = result.degenerate;

endmodule

@@ rtl/core/vna_checker.sv @@
// vna_checker: port-level assertions for vertex_normal_accumulator
// depends on vna_pkg; bound to the top level below
module vna_checker import vna_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [1:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // degenerate items carry zero components
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[57:10] == '0)
      else $error("degenerate item with nonzero normal");

   // unit components stay within Q1.14 one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[25:10]) <= 16'sd16384
         && $signed(rsp_tdata[25:10]) >= -16'sd16384
         && $signed(rsp_tdata[41:26]) <= 16'sd16384
         && $signed(rsp_tdata[41:26]) >= -16'sd16384
         && $signed(rsp_tdata[57:42]) <= 16'sd16384
         && $signed(rsp_tdata[57:42]) >= -16'sd16384)
      else $error("normal component out of range");

   // nothing leaves or enters in the cycle after reset (clearing pass)
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

endmodule

bind vertex_normal_accumulator vna_checker u_checker (.*);
